// ===== rtl/ais_pkg.sv =====
package ais_pkg;

	localparam int unsigned AIS_DATA_W    = 32;
	localparam int unsigned AIS_MAX_ITEMS = 16;

	typedef logic signed [AIS_DATA_W-1:0] ais_data_t;

	typedef enum logic {
		ST_LOAD,
		ST_DRAIN
	} ais_state_t;

	typedef struct packed {
		logic insert;
		logic shift;
	} ais_cell_ctrl_t;

endpackage

// ===== rtl/ais_in_if.sv =====
interface ais_in_if;
	import ais_pkg::*;

	logic      valid;
	logic      ready;
	ais_data_t value;
	logic      last;

	modport source (output valid, output value, output last, input ready);
	modport sink (input valid, input value, input last, output ready);

endinterface

// ===== rtl/ais_out_if.sv =====
interface ais_out_if;
	import ais_pkg::*;

	logic      valid;
	logic      ready;
	ais_data_t sorted_value;
	logic      last_res;
	logic      overflow;

	modport source (output valid, output sorted_value, output last_res, output overflow,
		input ready);
	modport sink (input valid, input sorted_value, input last_res, input overflow,
		output ready);

endinterface

// ===== rtl/ais_cell.sv =====
module ais_cell (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ais_pkg::ais_cell_ctrl_t ctrl,
	input  ais_pkg::ais_data_t      new_value,
	input  ais_pkg::ais_data_t      left_value,
	input  logic                    left_full,
	input  logic                    left_ins,
	input  ais_pkg::ais_data_t      right_value,
	input  logic                    right_full,
	output ais_pkg::ais_data_t      value,
	output logic                    full,
	output logic                    ins
);
	import ais_pkg::*;

	ais_data_t value_q;
	logic      full_q;

	// The cell lies at or beyond the insertion point of the new value.
	assign ins = !full_q || (new_value < value_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (ctrl.shift) begin
			full_q <= right_full;
		end else if (ctrl.insert && ins) begin
			full_q <= left_ins ? left_full : 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			value_q <= right_value;
		end else if (ctrl.insert && ins) begin
			value_q <= left_ins ? left_value : new_value;
		end
	end

	assign value = value_q;
	assign full  = full_q;

endmodule

// ===== rtl/ascending_integer_sorter.sv =====
// Sorts a set of signed 32-bit values in ascending order. Elements enter one per
// cycle while loading, on the elements channel, into a chain of MAX_ITEMS
// compare-and-shift cells that keeps the held values sorted as they arrive. The
// beat with last set closes the set; the block then stops taking elements and
// drains the chain from its head, one result per cycle while the results channel
// is ready, and the next set can start in the cycle after the final result.
// Elements beyond MAX_ITEMS are dropped and every result of that set carries
// overflow.
module ascending_integer_sorter #(
	parameter int unsigned MAX_ITEMS = ais_pkg::AIS_MAX_ITEMS
) (
	input logic      clk,
	input logic      arst_n,
	ais_in_if.sink   elements,
	ais_out_if.source results
);
	import ais_pkg::*;

	ais_state_t     state_q, state_d;
	logic           dropped_q;
	ais_cell_ctrl_t ctrl;
	logic           in_acc, out_acc;

	ais_data_t cell_value [MAX_ITEMS+1];
	logic      cell_full  [MAX_ITEMS+1];
	logic      cell_ins   [MAX_ITEMS+1];

	assign in_acc  = elements.valid && elements.ready;
	assign out_acc = results.valid && results.ready;

	assign ctrl.insert = in_acc && !cell_full[MAX_ITEMS-1];
	assign ctrl.shift  = out_acc;

	// Tail terminators of the chain.
	assign cell_value[MAX_ITEMS] = '0;
	assign cell_full[MAX_ITEMS]  = 1'b0;
	assign cell_ins[MAX_ITEMS]   = 1'b1;

	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
		ais_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.new_value   (elements.value),
			.left_value  ((i == 0) ? '0 : cell_value[(i == 0) ? 0 : i-1]),
			.left_full   ((i == 0) ? 1'b1 : cell_full[(i == 0) ? 0 : i-1]),
			.left_ins    ((i == 0) ? 1'b0 : cell_ins[(i == 0) ? 0 : i-1]),
			.right_value (cell_value[i+1]),
			.right_full  (cell_full[i+1]),
			.value       (cell_value[i]),
			.full        (cell_full[i]),
			.ins         (cell_ins[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			dropped_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc && cell_full[MAX_ITEMS-1]) begin
				dropped_q <= 1'b1;
			end else if (out_acc && results.last_res) begin
				dropped_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d          = state_q;
		elements.ready   = 1'b0;
		results.valid    = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				elements.ready = 1'b1;
				if (in_acc && elements.last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				results.valid = cell_full[0];
				if (out_acc && results.last_res) begin
					state_d = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	assign results.sorted_value = cell_value[0];
	assign results.last_res     = !cell_full[1];
	assign results.overflow     = dropped_q;

endmodule

// ===== rtl/ais_checker.sv =====
module ais_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic in_last,
	input logic out_valid,
	input logic out_ready,
	input logic out_last,
	input logic out_overflow
);

	// Loading and draining never overlap.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("Results offered while elements are taken.");

	// A closing beat starts the drain in the next cycle.
	a_drain_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_last) |=> out_valid)
		else $error("No result after the closing beat.");

	// Results keep coming until the final one is taken.
	a_drain_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !(out_ready && out_last)) |=> (out_valid && !in_ready))
		else $error("Drain stopped before the final result.");

	// The overflow flag is the same on every result of a set.
	a_overflow_steady: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !out_last) |=> (out_overflow == $past(out_overflow)))
		else $error("Overflow changed within a set.");

	// Taking the final result reopens the input.
	a_reopen: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && out_last) |=> (in_ready && !out_valid))
		else $error("Input not reopened after the final result.");

endmodule

bind ascending_integer_sorter ais_checker u_ais_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (elements.valid),
	.in_ready     (elements.ready),
	.in_last      (elements.last),
	.out_valid    (results.valid),
	.out_ready    (results.ready),
	.out_last     (results.last_res),
	.out_overflow (results.overflow)
);
